// ===== design/nce_pkg.sv =====
// Shared constants and types for the periodic neighbour cell enumerator.
// No dependencies; every other design file imports this package.
package nce_pkg;

    localparam int MAX_CELLS = 64;
    localparam int WORD_W    = 32;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = CELL_W + 1;
    localparam int CFG_CNT_W = 7;
    localparam int CFG_MASK_W = 3;
    localparam int NAXES     = 3;
    localparam int NUM_W     = WORD_W + CELL_W;

    localparam int DIV_FIRST = 2;
    localparam int DIV_LAST  = DIV_FIRST + CELL_W - 1;
    localparam int HOME_STG  = DIV_LAST + 1;
    localparam int NSTG      = HOME_STG + 1;

    localparam int S_TDATA_W = NAXES * WORD_W;
    localparam int M_TDATA_W = ((NAXES * CELL_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [WORD_W-1:0] LEN_ONE = WORD_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MASK  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_METRIC = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_X    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_Y    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_Z    = CFG_IDX_W'(7);

    typedef struct packed {
        logic [NAXES-1:0][CNT_W-1:0]  cells;
        logic [NAXES-1:0]             full;
        logic [WORD_W-1:0]            metric;
        logic [NAXES-1:0][WORD_W-1:0] space;
    } cfg_t;

    typedef struct packed {
        logic [NAXES-1:0][CELL_W-1:0] home;
        logic                         oor;
    } home_t;

endpackage

// ===== design/nce_front.sv =====
// Home cell pipeline: clamp, scale, restoring divide one quotient bit per stage, clamp.
// Depends on nce_pkg.
module nce_front import nce_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [NAXES-1:0][WORD_W-1:0] in_pos,
    output logic                         out_valid,
    input  logic                         out_ready,
    output home_t                        out_home
);

    typedef struct packed {
        logic [NAXES-1:0]             oor;
        logic [NAXES-1:0]             sat;
        logic [NAXES-1:0][NUM_W-1:0]  rem;
        logic [NAXES-1:0][CELL_W-1:0] quo;
    } stage_t;

    stage_t                            st_reg  [NSTG];
    stage_t                            st_next [NSTG];
    logic [NSTG-1:0]                   vld_reg;
    logic [NSTG-1:0]                   vld_in;
    logic [NSTG:0]                     rdy;
    logic [NAXES-1:0][WORD_W-1:0]      den;
    logic [NAXES-1:0][CELL_W-1:0]      cmax;
    logic [NAXES-1:0][CNT_W+WORD_W-1:0] prod;

    always_comb begin
        rdy[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_in = {vld_reg[NSTG-2:0], in_valid};

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            den[a]  = cfg.full[a] ? cfg.space[a] : cfg.metric;
            cmax[a] = CELL_W'(cfg.cells[a] - CNT_W'(1));
            prod[a] = (CNT_W+WORD_W)'(cfg.cells[a]) *
                      (CNT_W+WORD_W)'(st_reg[0].rem[a][WORD_W-1:0]);
        end
    end

    always_comb begin
        logic [WORD_W-1:0] p;
        logic [NUM_W-1:0]  dsh;
        int                b;

        // clamp into the box
        st_next[0] = '0;
        for (int a = 0; a < NAXES; a++) begin
            p = in_pos[a];
            if (p >= cfg.space[a]) begin
                p = cfg.space[a] - WORD_W'(1);
                st_next[0].oor[a] = 1'b1;
            end
            st_next[0].rem[a] = NUM_W'(p);
        end

        // numerator and saturation
        st_next[1] = st_reg[0];
        for (int a = 0; a < NAXES; a++) begin
            p = st_reg[0].rem[a][WORD_W-1:0];
            if (cfg.full[a]) begin
                st_next[1].rem[a] = prod[a][NUM_W-1:0];
                st_next[1].sat[a] = 1'b0;
            end else begin
                st_next[1].rem[a] = NUM_W'(p);
                st_next[1].sat[a] = (p >> CELL_W) >= cfg.metric;
            end
        end

        for (int k = DIV_FIRST; k <= DIV_LAST; k++) begin
            st_next[k] = st_reg[k-1];
            b = DIV_LAST - k;
            for (int a = 0; a < NAXES; a++) begin
                dsh = NUM_W'(den[a]) << b;
                if (st_reg[k-1].rem[a] >= dsh) begin
                    st_next[k].rem[a] = st_reg[k-1].rem[a] - dsh;
                    st_next[k].quo[a] = st_reg[k-1].quo[a] | (CELL_W'(1) << b);
                end
            end
        end

        // clamp to the last cell
        st_next[HOME_STG] = st_reg[HOME_STG-1];
        for (int a = 0; a < NAXES; a++) begin
            if (st_reg[HOME_STG-1].sat[a] || st_reg[HOME_STG-1].quo[a] > cmax[a]) begin
                st_next[HOME_STG].quo[a] = cmax[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];

    always_comb begin
        out_home.oor = |st_reg[HOME_STG].oor;
        for (int a = 0; a < NAXES; a++) begin
            out_home.home[a] = st_reg[HOME_STG].quo[a];
        end
    end

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DIV_LAST] |->
            (st_reg[DIV_LAST].sat[0] || st_reg[DIV_LAST].rem[0] < NUM_W'(den[0])) &&
            (st_reg[DIV_LAST].sat[1] || st_reg[DIV_LAST].rem[1] < NUM_W'(den[1])) &&
            (st_reg[DIV_LAST].sat[2] || st_reg[DIV_LAST].rem[2] < NUM_W'(den[2])))
        else $error("divider remainder not below divisor");

endmodule

// ===== design/nce_emit.sv =====
// Neighbour sequencer: walks the offsets of one query and drives the output register.
// Depends on nce_pkg.
module nce_emit import nce_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  home_t                in_home,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic [0:0]           m_tuser
);

    localparam logic [1:0] OFS_DOWN = 2'd0;
    localparam logic [1:0] OFS_ZERO = 2'd1;
    localparam logic [1:0] OFS_UP   = 2'd2;

    logic                         busy_reg, busy_next;
    home_t                        item_reg;
    logic [NAXES-1:0][1:0]        idx_reg, idx_next, idx_lo, idx_hi;
    logic [NAXES-1:0]             at_hi;
    logic [NAXES-1:0][CELL_W-1:0] cmax, nbr_cell;
    logic                         last_now, out_free, emit, load;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]         m_tdata_reg;
    logic                         m_tlast_reg;
    logic [0:0]                   m_tuser_reg;

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            idx_lo[a] = (cfg.cells[a] > CNT_W'(1)) ? OFS_DOWN : OFS_ZERO;
            idx_hi[a] = (cfg.cells[a] > CNT_W'(2)) ? OFS_UP : OFS_ZERO;
            at_hi[a]  = idx_reg[a] == idx_hi[a];
            cmax[a]   = CELL_W'(cfg.cells[a] - CNT_W'(1));
            case (idx_reg[a])
                OFS_DOWN: begin
                    nbr_cell[a] = (item_reg.home[a] == '0) ? cmax[a]
                                                            : item_reg.home[a] - CELL_W'(1);
                end
                OFS_UP: begin
                    nbr_cell[a] = (item_reg.home[a] == cmax[a]) ? '0
                                                                 : item_reg.home[a] + CELL_W'(1);
                end
                default: begin
                    nbr_cell[a] = item_reg.home[a];
                end
            endcase
        end
    end

    assign last_now = &at_hi;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign in_ready = !busy_reg || (emit && last_now);
    assign load     = in_valid && in_ready;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = idx_lo;
        end else if (emit && !last_now) begin
            if (!at_hi[0]) begin
                idx_next[0] = idx_reg[0] + 2'd1;
            end else begin
                idx_next[0] = idx_lo[0];
                if (!at_hi[1]) begin
                    idx_next[1] = idx_reg[1] + 2'd1;
                end else begin
                    idx_next[1] = idx_lo[1];
                    idx_next[2] = idx_reg[2] + 2'd1;
                end
            end
        end
    end

    always_comb begin
        if (load) begin
            busy_next = 1'b1;
        end else if (emit && last_now) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_comb begin
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= {NAXES{OFS_ZERO}};
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_home;
        end
        if (emit) begin
            m_tdata_reg    <= M_TDATA_W'(nbr_cell);
            m_tlast_reg    <= last_now;
            m_tuser_reg[0] <= item_reg.oor;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_idx_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |->
            idx_reg[0] >= idx_lo[0] && idx_reg[0] <= idx_hi[0] &&
            idx_reg[1] >= idx_lo[1] && idx_reg[1] <= idx_hi[1] &&
            idx_reg[2] >= idx_lo[2] && idx_reg[2] <= idx_hi[2])
        else $error("offset index outside its span");

    a_home_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |->
            CNT_W'(item_reg.home[0]) < cfg.cells[0] &&
            CNT_W'(item_reg.home[1]) < cfg.cells[1] &&
            CNT_W'(item_reg.home[2]) < cfg.cells[2])
        else $error("home cell outside the grid");

    a_cell_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |->
            CNT_W'(m_tdata_reg[CELL_W-1:0]) < cfg.cells[0] &&
            CNT_W'(m_tdata_reg[2*CELL_W-1:CELL_W]) < cfg.cells[1] &&
            CNT_W'(m_tdata_reg[3*CELL_W-1:2*CELL_W]) < cfg.cells[2])
        else $error("emitted cell outside the grid");

endmodule

// ===== design/neighbor_cell_enumerator_pbc.sv =====
// Top level of the periodic neighbour cell enumerator: config registers and stream ports.
// Depends on nce_pkg, nce_front and nce_emit.
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tdata: pos_x, pos_y, pos_z
//  m_        out        m_tvalid / m_tready    m_tdata: cells; m_tlast; m_tuser: out_of_range
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The home cell pipeline takes a new query every cycle unless stalled. The sequencer then
// emits one neighbour cell per cycle while m_ tready allows, through a single output
// register, 1 to 27 transfers per query (the product of the per-axis offset counts), so that
// count sets the sustained query rate. Reset is synchronous: it empties the pipeline and the
// output register and restores the default configuration. A stall on m_ tready holds every
// stage in place; stages that are empty still fill from behind.
module neighbor_cell_enumerator_pbc import nce_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pos_x, pos_y, pos_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // cell_x, cell_y, cell_z, zero fill
    output logic                 m_tlast,
    output logic [0:0]           m_tuser,   // out_of_range
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    cfg_t                         cfg_reg;
    logic                         cfg_fire;
    logic                         home_valid, home_ready;
    home_t                        home_item;
    logic [NAXES-1:0][WORD_W-1:0] pos;

    function automatic logic [CNT_W-1:0] sat_cells(input logic [CFG_CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CFG_CNT_W'(MAX_CELLS)) begin
            r = CNT_W'(MAX_CELLS);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] nonzero(input logic [WORD_W-1:0] v);
        return (v == '0) ? WORD_W'(1) : v;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cells  <= {NAXES{CNT_W'(1)}};
            cfg_reg.full   <= '0;
            cfg_reg.metric <= LEN_ONE;
            cfg_reg.space  <= {NAXES{LEN_ONE}};
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_CELLS_X:    cfg_reg.cells[0] <= sat_cells(cfg_data[CFG_CNT_W-1:0]);
                REG_CELLS_Y:    cfg_reg.cells[1] <= sat_cells(cfg_data[CFG_CNT_W-1:0]);
                REG_CELLS_Z:    cfg_reg.cells[2] <= sat_cells(cfg_data[CFG_CNT_W-1:0]);
                REG_FULL_MASK:  cfg_reg.full     <= cfg_data[CFG_MASK_W-1:0];
                REG_MIN_METRIC: cfg_reg.metric   <= nonzero(cfg_data);
                REG_SPACE_X:    cfg_reg.space[0] <= nonzero(cfg_data);
                REG_SPACE_Y:    cfg_reg.space[1] <= nonzero(cfg_data);
                REG_SPACE_Z:    cfg_reg.space[2] <= nonzero(cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            pos[a] = s_tdata[a*WORD_W +: WORD_W];
        end
    end

    nce_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    (pos),
        .out_valid (home_valid),
        .out_ready (home_ready),
        .out_home  (home_item)
    );

    nce_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (home_valid),
        .in_ready (home_ready),
        .in_home  (home_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/sv/tb_neighbor_cell_enumerator_pbc.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for neighbor_cell_enumerator_pbc: queries positions, predicts
// the wrapped neighbour cells of each query and checks every m_ transfer against them.
// Depends on nce_pkg and the design files only.
module tb_neighbor_cell_enumerator_pbc;
    import nce_pkg::*;

    localparam int  HALF_PERIOD   = 5;
    localparam int  SETTLE_CYCLES = 24;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  RAND_PHASES   = 8;
    localparam int  PHASE_ITEMS   = 32;

    typedef struct packed {
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [CELL_W-1:0] cz;
        logic              last;
        logic              oor;
    } nbr_cell_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    // shadow of the configuration registers
    logic [CFG_CNT_W-1:0]  sh_cells [NAXES];
    logic [CFG_MASK_W-1:0] sh_full;
    logic [WORD_W-1:0]     sh_metric;
    logic [WORD_W-1:0]     sh_space [NAXES];

    logic [S_TDATA_W-1:0] pending_pos[$];
    nbr_cell_t            nbr_expected[$];
    int                   queued_cnt   = 0;
    int                   accepted_cnt = 0;
    int                   errors       = 0;
    int                   cycles       = 0;
    int                   src_gap      = 0;
    int                   snk_gap      = 0;
    bit                   src_idle_on  = 1'b1;
    bit                   snk_idle_on  = 1'b1;

    neighbor_cell_enumerator_pbc dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [WORD_W-1:0] val);
        case (idx)
            REG_CELLS_X:    sh_cells[0] = val[CFG_CNT_W-1:0];
            REG_CELLS_Y:    sh_cells[1] = val[CFG_CNT_W-1:0];
            REG_CELLS_Z:    sh_cells[2] = val[CFG_CNT_W-1:0];
            REG_FULL_MASK:  sh_full     = val[CFG_MASK_W-1:0];
            REG_MIN_METRIC: sh_metric   = val;
            REG_SPACE_X:    sh_space[0] = val;
            REG_SPACE_Y:    sh_space[1] = val;
            REG_SPACE_Z:    sh_space[2] = val;
            default: ;
        endcase
    endfunction

    function automatic void enumerate_neighbours(input logic [S_TDATA_W-1:0] pos);
        longint    cnt[NAXES];
        longint    home[NAXES];
        longint    p, s, m, v;
        int        lo[NAXES], hi[NAXES];
        int        off[NAXES];
        int        total, n;
        bit        oor;
        nbr_cell_t e;
        logic [CELL_W-1:0] c[NAXES];
        oor = 1'b0;
        for (int a = 0; a < NAXES; a++) begin
            cnt[a] = longint'(sh_cells[a]);
            if (cnt[a] < 1) cnt[a] = 1;
            if (cnt[a] > MAX_CELLS) cnt[a] = MAX_CELLS;
            p = longint'(pos[a*WORD_W +: WORD_W]);
            s = longint'(sh_space[a]);
            if (s == 0) s = 1;
            m = longint'(sh_metric);
            if (m == 0) m = 1;
            if (p >= s) begin
                p   = s - 1;
                oor = 1'b1;
            end
            if (sh_full[a]) begin
                home[a] = (cnt[a] * p) / s;
            end else begin
                home[a] = p / m;
                if (home[a] > cnt[a] - 1) home[a] = cnt[a] - 1;
            end
            lo[a] = (cnt[a] > 1) ? -1 : 0;
            hi[a] = (cnt[a] > 2) ? 1 : 0;
        end
        total = (hi[0] - lo[0] + 1) * (hi[1] - lo[1] + 1) * (hi[2] - lo[2] + 1);
        n = 0;
        for (int dz = lo[2]; dz <= hi[2]; dz++) begin
            for (int dy = lo[1]; dy <= hi[1]; dy++) begin
                for (int dx = lo[0]; dx <= hi[0]; dx++) begin
                    off[0] = dx;
                    off[1] = dy;
                    off[2] = dz;
                    for (int a = 0; a < NAXES; a++) begin
                        v    = home[a] + cnt[a] + off[a];
                        c[a] = CELL_W'(v % cnt[a]);
                    end
                    n++;
                    e.cx   = c[0];
                    e.cy   = c[1];
                    e.cz   = c[2];
                    e.last = (n == total);
                    e.oor  = oor;
                    nbr_expected.push_back(e);
                end
            end
        end
    endfunction

    // query driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                enumerate_neighbours(s_tdata);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_pos.size() > 0) begin
                    s_tdata  <= pending_pos.pop_front();
                    s_tvalid <= 1'b1;
                    if (src_idle_on && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : monitor
        nbr_cell_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (nbr_expected.size() == 0) begin
                    report_mismatch("transfer with nothing expected, cell_x", m_tdata[5:0], -1);
                end else begin
                    want = nbr_expected.pop_front();
                    if (m_tdata[0 +: CELL_W] !== want.cx)
                        report_mismatch("cell_x", m_tdata[0 +: CELL_W], want.cx);
                    if (m_tdata[CELL_W +: CELL_W] !== want.cy)
                        report_mismatch("cell_y", m_tdata[CELL_W +: CELL_W], want.cy);
                    if (m_tdata[2*CELL_W +: CELL_W] !== want.cz)
                        report_mismatch("cell_z", m_tdata[2*CELL_W +: CELL_W], want.cz);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                    if (m_tuser[0] !== want.oor)
                        report_mismatch("out_of_range", m_tuser[0], want.oor);
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (snk_idle_on && $urandom_range(0, 5) == 0)
                    snk_gap = $urandom_range(1, 4);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_neighbor_cell_enumerator_pbc failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pos(input logic [WORD_W-1:0] px, input logic [WORD_W-1:0] py,
                            input logic [WORD_W-1:0] pz);
        pending_pos.push_back({pz, py, px});
        queued_cnt++;
    endtask

    task automatic drain_results();
        do @(negedge aclk); while (accepted_cnt != queued_cnt || nbr_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_count();
        logic [WORD_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 11))
            0:       r[CFG_CNT_W-1:0] = '0;
            1:       r[CFG_CNT_W-1:0] = CFG_CNT_W'(1);
            2:       r[CFG_CNT_W-1:0] = CFG_CNT_W'(2);
            3:       r[CFG_CNT_W-1:0] = CFG_CNT_W'(3);
            4:       r[CFG_CNT_W-1:0] = CFG_CNT_W'(MAX_CELLS);
            5:       r[CFG_CNT_W-1:0] = CFG_CNT_W'($urandom_range(MAX_CELLS + 1, 127));
            default: r[CFG_CNT_W-1:0] = CFG_CNT_W'($urandom_range(1, MAX_CELLS));
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_len();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 1;
            2:       return '1;
            3:       return $urandom;
            default: return $urandom_range(LEN_ONE, 256 * LEN_ONE);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_pos(input logic [WORD_W-1:0] len);
        longint s;
        s = longint'(len);
        if (s == 0) s = 1;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return '0;
            2:       return WORD_W'(s - 1);
            3:       return WORD_W'(s);
            4:       return '1;
            default: return WORD_W'({$urandom, $urandom} % s);
        endcase
    endfunction

    task automatic random_setup();
        write_reg(REG_CELLS_X, pick_count());
        write_reg(REG_CELLS_Y, pick_count());
        write_reg(REG_CELLS_Z, pick_count());
        write_reg(REG_FULL_MASK, $urandom);
        write_reg(REG_SPACE_X, pick_len());
        write_reg(REG_SPACE_Y, pick_len());
        write_reg(REG_SPACE_Z, pick_len());
        case ($urandom_range(0, 7))
            0:       write_reg(REG_MIN_METRIC, '0);
            1:       write_reg(REG_MIN_METRIC, 1);
            2:       write_reg(REG_MIN_METRIC, '1);
            default: write_reg(REG_MIN_METRIC, $urandom_range(1, 8 * LEN_ONE));
        endcase
    endtask

    initial begin : stimulus
        for (int a = 0; a < NAXES; a++) begin
            sh_cells[a] = CFG_CNT_W'(1);
            sh_space[a] = LEN_ONE;
        end
        sh_full   = '0;
        sh_metric = LEN_ONE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: one cell per axis
        send_pos('0, '0, '0);
        send_pos(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        send_pos(LEN_ONE, '0, '0);
        send_pos('1, '1, '1);
        drain_results();

        // writes beyond the register list must be dropped
        for (int i = int'(REG_SPACE_Z) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        send_pos(32'h0000_8000, '0, LEN_ONE);
        send_pos('0, 32'h0001_2345, '0);
        drain_results();

        // three cells per axis, wrap at both ends
        write_reg(REG_CELLS_X, 3);
        write_reg(REG_CELLS_Y, 3);
        write_reg(REG_CELLS_Z, 3);
        write_reg(REG_FULL_MASK, '0);
        write_reg(REG_MIN_METRIC, LEN_ONE);
        write_reg(REG_SPACE_X, 3 * LEN_ONE);
        write_reg(REG_SPACE_Y, 3 * LEN_ONE);
        write_reg(REG_SPACE_Z, 3 * LEN_ONE);
        send_pos('0, '0, '0);
        send_pos(32'h0002_1000, 32'h0001_8000, '0);
        send_pos(32'h0002_FFFF, 32'h0002_FFFF, 32'h0002_FFFF);
        send_pos(3 * LEN_ONE, 32'h0001_2345, 5 * LEN_ONE);
        drain_results();

        // saturated counts, zero lengths and zero metric
        write_reg(REG_CELLS_X, 32'hFFFF_FF80);
        write_reg(REG_CELLS_Y, '1);
        write_reg(REG_CELLS_Z, 2);
        write_reg(REG_FULL_MASK, 32'hFFFF_FFFD);
        write_reg(REG_MIN_METRIC, '0);
        write_reg(REG_SPACE_X, '1);
        write_reg(REG_SPACE_Y, '0);
        write_reg(REG_SPACE_Z, 1);
        send_pos('0, '0, '0);
        send_pos(32'hFFFF_FFFE, 32'h7FFF_FFFF, '0);
        send_pos('1, 1, 1);
        drain_results();

        // largest grid, full mode on every axis
        write_reg(REG_CELLS_X, MAX_CELLS);
        write_reg(REG_CELLS_Y, MAX_CELLS);
        write_reg(REG_CELLS_Z, MAX_CELLS);
        write_reg(REG_FULL_MASK, '1);
        write_reg(REG_MIN_METRIC, '1);
        write_reg(REG_SPACE_X, MAX_CELLS * LEN_ONE);
        write_reg(REG_SPACE_Y, MAX_CELLS * LEN_ONE);
        write_reg(REG_SPACE_Z, MAX_CELLS * LEN_ONE);
        send_pos('0, '0, '0);
        send_pos(32'h003F_FFFF, 32'h003F_FFFF, 32'h003F_FFFF);
        send_pos(32'h8000_0000, '0, 32'h001F_0000);
        drain_results();

        // metric of one with clamping, mixed counts
        write_reg(REG_CELLS_Y, 2);
        write_reg(REG_CELLS_Z, 3);
        write_reg(REG_FULL_MASK, '0);
        write_reg(REG_MIN_METRIC, 1);
        write_reg(REG_SPACE_X, '1);
        write_reg(REG_SPACE_Y, '1);
        write_reg(REG_SPACE_Z, '1);
        send_pos(5, 32'hFFFF_FFFE, 32'h3F);
        send_pos(32'h0000_003F, 1, 2);
        drain_results();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            src_idle_on = (ph != 2) && (ph != RAND_PHASES - 1);
            snk_idle_on = (ph != 4) && (ph != RAND_PHASES - 1);
            random_setup();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_pos(pick_pos(sh_space[0]), pick_pos(sh_space[1]), pick_pos(sh_space[2]));
                // hold the sender until the block has emptied
                if (i == PHASE_ITEMS / 2 && ph % 3 == 1)
                    drain_results();
            end
            drain_results();
        end

        if (errors == 0 && nbr_expected.size() == 0) begin
            $display("tb_neighbor_cell_enumerator_pbc passed");
        end else begin
            $display("tb_neighbor_cell_enumerator_pbc failed");
        end
        $finish;
    end

endmodule
